[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[design/tpab_pkg.sv]
// ----------------------------------------------------------------------------
// tpab_pkg
// Types, widths and helper functions for the tiled pixel alpha blend unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tpab_pkg;

    localparam int COORD_W       = 11;
    localparam int CHAN_W        = 8;
    localparam int WORD_W        = 32;
    localparam int OFFSET_W      = 25;
    localparam int PROD_W        = 2 * CHAN_W;
    localparam int SWZ_W         = 16;
    localparam int BLOCK_SHIFT   = 7;
    localparam int TILE_IDX_W    = COORD_W - BLOCK_SHIFT;
    localparam int NUM_CHAN      = 3;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [PROD_W:0]   ROUND_BIAS   = 17'd127;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SWZ_W-1:0]   swz_t;
    typedef logic [OFFSET_W-1:0] offset_t;

    // XOR mix of coordinate bits inside one 128x128 block
    function automatic swz_t swizzle(input coord_t x, input coord_t y);
        logic [31:0] xe;
        logic [31:0] ye;
        logic [31:0] m;
        xe = 32'(x);
        ye = 32'(y);
        m  = ((ye << 4) & 32'h0000_0070) ^ ((ye << 5) & 32'h0000_0F00) ^
             ((ye << 9) & 32'h0000_1000) ^ ((ye << 8) & 32'h0000_4000) ^
             ((xe << 2) & 32'h0000_000C) ^ ((xe << 5) & 32'h0000_0380) ^
             ((xe << 4) & 32'h0000_0400) ^ ((xe << 6) & 32'h0000_0800) ^
             ((xe << 9) & 32'h0000_A000);
        return m[SWZ_W-1:0];
    endfunction

    // floor(s / 255), exact while the quotient fits in 8 bits (s below 65280)
    function automatic chan_t div255(input prod_t s);
        logic [PROD_W:0] t;
        t = {1'b0, s} + (PROD_W+1)'(s[PROD_W-1:CHAN_W]) + (PROD_W+1)'(1);
        return t[PROD_W-1:CHAN_W];
    endfunction

endpackage

`default_nettype wire

[design/tiled_pixel_alpha_blend_unit.sv]
// Path: an accepted pixel moves through the stage 1 to stage 4 registers; m_valid is v4_reg.
// Throughput: one pixel per cycle; a stalled stage holds, empty stages fill.
// Stages: input register, multiply, add, divide-by-255 into output register.
// Reset: synchronous active-low aresetn clears all stage valids and
// frame_select to 0; payload registers are not reset.
// ----------------------------------------------------------------------------
// tiled_pixel_alpha_blend_unit
// Per-pixel tiled framebuffer address generation and alpha blend.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tiled_pixel_alpha_blend_unit #(
    parameter int FRAME_WIDTH = 1920,
    parameter int FB_STRIDE   = 16777216
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic                          cfg_data,

    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire logic [tpab_pkg::COORD_W-1:0]  s_pixel_x,
    input  wire logic [tpab_pkg::COORD_W-1:0]  s_pixel_y,
    input  wire logic [tpab_pkg::CHAN_W-1:0]   s_red,
    input  wire logic [tpab_pkg::CHAN_W-1:0]   s_green,
    input  wire logic [tpab_pkg::CHAN_W-1:0]   s_blue,
    input  wire logic [tpab_pkg::CHAN_W-1:0]   s_alpha,
    input  wire logic [tpab_pkg::WORD_W-1:0]   s_background_word,

    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output      logic [tpab_pkg::OFFSET_W-1:0] m_byte_offset,
    output      logic                          m_write_enable,
    output      logic [tpab_pkg::WORD_W-1:0]   m_pixel_word
);

    import tpab_pkg::*;

    localparam int BLOCKS_PER_ROW = (FRAME_WIDTH + 127) / 128;
    localparam int BPR_W          = $clog2(BLOCKS_PER_ROW + 1);
    localparam int BLK_W          = BPR_W + TILE_IDX_W;
    localparam offset_t FRAME_BASE = OFFSET_W'(FB_STRIDE);

    // config
    logic frame_select_reg, frame_select_next;

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: input register
    coord_t                    x1_reg, x1_next;
    coord_t                    y1_reg, y1_next;
    chan_t [NUM_CHAN-1:0]      fg1_reg, fg1_next;
    chan_t [NUM_CHAN-1:0]      bg1_reg, bg1_next;
    chan_t                     a1_reg, a1_next;

    // stage 2: products, block index, swizzle
    prod_t [NUM_CHAN-1:0]      fa2_reg, fa2_next;
    prod_t [NUM_CHAN-1:0]      bb2_reg, bb2_next;
    logic [BLK_W-1:0]          blk2_reg, blk2_next;
    swz_t                      swz2_reg, swz2_next;
    logic                      we2_reg, we2_next;

    // stage 3: rounded sums, offset
    prod_t [NUM_CHAN-1:0]      sum3_reg, sum3_next;
    offset_t                   off3_reg, off3_next;
    logic                      we3_reg, we3_next;

    // stage 4: output register
    offset_t                   off4_reg, off4_next;
    logic                      we4_reg, we4_next;
    logic [WORD_W-1:0]         word4_reg, word4_next;

    chan_t                     a_inv;

    // handshake
    always_comb begin
        rdy4    = !v4_reg || m_ready;
        rdy3    = !v3_reg || rdy4;
        rdy2    = !v2_reg || rdy3;
        rdy1    = !v1_reg || rdy2;
        s_ready = rdy1;
        v1_next = rdy1 ? s_valid : v1_reg;
        v2_next = rdy2 ? v1_reg  : v2_reg;
        v3_next = rdy3 ? v2_reg  : v3_reg;
        v4_next = rdy4 ? v3_reg  : v4_reg;
    end

    assign cfg_ready         = 1'b1;
    assign frame_select_next = (cfg_valid && cfg_ready) ? cfg_data : frame_select_reg;

    // stage 1
    always_comb begin
        x1_next  = x1_reg;
        y1_next  = y1_reg;
        fg1_next = fg1_reg;
        bg1_next = bg1_reg;
        a1_next  = a1_reg;
        if (s_valid && rdy1) begin
            x1_next  = s_pixel_x;
            y1_next  = s_pixel_y;
            fg1_next = {s_blue, s_green, s_red};
            bg1_next = {s_background_word[23:16], s_background_word[15:8],
                        s_background_word[7:0]};
            a1_next  = s_alpha;
        end
    end

    // stage 2
    assign a_inv = ALPHA_OPAQUE - a1_reg;

    always_comb begin
        fa2_next  = fa2_reg;
        bb2_next  = bb2_reg;
        blk2_next = blk2_reg;
        swz2_next = swz2_reg;
        we2_next  = we2_reg;
        if (v1_reg && rdy2) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
                fa2_next[i] = PROD_W'(fg1_reg[i]) * PROD_W'(a1_reg);
                bb2_next[i] = PROD_W'(bg1_reg[i]) * PROD_W'(a_inv);
            end
            blk2_next = BLK_W'(BLK_W'(y1_reg[COORD_W-1:BLOCK_SHIFT]) *
                               BLK_W'(BLOCKS_PER_ROW))
                      + BLK_W'(x1_reg[COORD_W-1:BLOCK_SHIFT]);
            swz2_next = swizzle(x1_reg, y1_reg);
            we2_next  = (a1_reg != '0);
        end
    end

    // stage 3
    always_comb begin
        sum3_next = sum3_reg;
        off3_next = off3_reg;
        we3_next  = we3_reg;
        if (v2_reg && rdy3) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
                sum3_next[i] = PROD_W'({1'b0, fa2_reg[i]} + {1'b0, bb2_reg[i]} + ROUND_BIAS);
            end
            off3_next = OFFSET_W'({blk2_reg, 16'b0}) + OFFSET_W'(swz2_reg)
                      + (frame_select_reg ? FRAME_BASE : '0);
            we3_next  = we2_reg;
        end
    end

    // stage 4
    always_comb begin
        off4_next  = off4_reg;
        we4_next   = we4_reg;
        word4_next = word4_reg;
        if (v3_reg && rdy4) begin
            off4_next  = off3_reg;
            we4_next   = we3_reg;
            word4_next = we3_reg ? {ALPHA_OPAQUE, div255(sum3_reg[2]), div255(sum3_reg[1]),
                                    div255(sum3_reg[0])}
                                 : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_select_reg <= 1'b0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
        end else begin
            frame_select_reg <= frame_select_next;
            v1_reg           <= v1_next;
            v2_reg           <= v2_next;
            v3_reg           <= v3_next;
            v4_reg           <= v4_next;
        end
    end

    always_ff @(posedge aclk) begin
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        fg1_reg   <= fg1_next;
        bg1_reg   <= bg1_next;
        a1_reg    <= a1_next;
        fa2_reg   <= fa2_next;
        bb2_reg   <= bb2_next;
        blk2_reg  <= blk2_next;
        swz2_reg  <= swz2_next;
        we2_reg   <= we2_next;
        sum3_reg  <= sum3_next;
        off3_reg  <= off3_next;
        we3_reg   <= we3_next;
        off4_reg  <= off4_next;
        we4_reg   <= we4_next;
        word4_reg <= word4_next;
    end

    assign m_valid        = v4_reg;
    assign m_byte_offset  = off4_reg;
    assign m_write_enable = we4_reg;
    assign m_pixel_word   = word4_reg;

    `ASSERT_CLK(a_skip_word_zero, m_valid && !m_write_enable |-> m_pixel_word == '0, "skipped pixel carries a non-zero word")
    `ASSERT_CLK(a_alpha_opaque, m_valid && m_write_enable |-> m_pixel_word[31:24] == ALPHA_OPAQUE, "written pixel alpha is not opaque")
    `ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid && !v1_reg && !v2_reg && !v3_reg, "pipeline not empty after reset")

endmodule

`default_nettype wire
